@@ hw/rtl/ssrd_pkg.sv @@
// Shared types and constants for the servo status reply deframer.
`default_nettype none
package ssrd_pkg;

	// Action codes of an input item.
	localparam logic [1:0] ACT_BEGIN   = 2'd0;
	localparam logic [1:0] ACT_BYTE    = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	// Receive phases.
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HUNT = 3'd1;
	localparam logic [2:0] PH_ID   = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_STAT = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;
	localparam logic [2:0] PH_CSUM = 3'd6;

	// Final status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOREP  = 3'd1;
	localparam logic [2:0] ST_BADID  = 3'd2;
	localparam logic [2:0] ST_BADLEN = 3'd3;
	localparam logic [2:0] ST_CRC    = 3'd4;

	// Result kinds.
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	// Configuration register indexes.
	localparam logic [0:0] REG_HUNT_LIMIT   = 1'd0;
	localparam logic [0:0] REG_REPLY_ENABLE = 1'd1;

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] BCAST_ID     = 8'hFE;
	localparam logic [8:0] LEN_EXTRA    = 9'd2;
	localparam logic [7:0] HUNT_DEFAULT = 8'd10;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [7:0] expected_id;
		logic [7:0] expected_len;
		logic       write_ack;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [2:0] comm_status;
		logic [7:0] servo_error;
		logic [7:0] reply_id;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] hunt_limit;
		logic       reply_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       prev_byte_ff;
		logic [7:0] hunt_count;
		logic [7:0] want_id;
		logic [7:0] want_len;
		logic [7:0] running_sum;
		logic [7:0] data_count;
		logic [7:0] got_id;
		logic [7:0] got_status;
	} rx_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ssrd_core.sv @@
// Deframer state registers and the per-item next-state and result logic.
`default_nettype none
module ssrd_core
	import ssrd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire cfg_t      cfg,
	output logic           has_result,
	output out_item_t      result
);

	rx_state_t state_q;
	rx_state_t state_nx;

	logic [7:0] sum_plus_b;
	logic [7:0] count_inc;

	assign sum_plus_b = state_q.running_sum + item.rx_byte;
	assign count_inc  = state_q.data_count + 8'd1;

	always_comb begin
		state_nx   = state_q;
		has_result = 1'b0;
		result     = '0;

		case (item.action)
			ACT_BEGIN: begin
				state_nx.want_id      = item.expected_id;
				state_nx.want_len     = item.write_ack ? 8'd0 : item.expected_len;
				state_nx.prev_byte_ff = 1'b0;
				state_nx.hunt_count   = '0;
				state_nx.running_sum  = '0;
				state_nx.data_count   = '0;
				state_nx.got_id       = '0;
				state_nx.got_status   = '0;
				if (item.write_ack && (item.expected_id == BCAST_ID || !cfg.reply_enable)) begin
					has_result         = 1'b1;
					result.kind        = KIND_FINAL;
					result.comm_status = ST_OK;
					result.last        = 1'b1;
					state_nx.phase     = PH_IDLE;
				end else begin
					state_nx.phase = PH_HUNT;
				end
			end
			ACT_TIMEOUT: begin
				if (state_q.phase != PH_IDLE) begin
					has_result         = 1'b1;
					result.kind        = KIND_FINAL;
					result.comm_status = ST_NOREP;
					result.reply_id    = state_q.got_id;
					result.last        = 1'b1;
					state_nx.phase     = PH_IDLE;
				end
			end
			ACT_BYTE: begin
				case (state_q.phase)
					PH_IDLE: begin
					end
					PH_HUNT: begin
						if (item.rx_byte == HDR_BYTE && state_q.prev_byte_ff) begin
							state_nx.phase = PH_ID;
						end else begin
							state_nx.prev_byte_ff = (item.rx_byte == HDR_BYTE);
							if (state_q.hunt_count >= cfg.hunt_limit) begin
								has_result         = 1'b1;
								result.kind        = KIND_FINAL;
								result.comm_status = ST_NOREP;
								result.last        = 1'b1;
								state_nx.phase     = PH_IDLE;
							end else begin
								state_nx.hunt_count = state_q.hunt_count + 8'd1;
							end
						end
					end
					PH_ID: begin
						state_nx.got_id      = item.rx_byte;
						state_nx.running_sum = item.rx_byte;
						if (item.rx_byte != state_q.want_id && state_q.want_id != BCAST_ID) begin
							has_result         = 1'b1;
							result.kind        = KIND_FINAL;
							result.comm_status = ST_BADID;
							result.reply_id    = item.rx_byte;
							result.last        = 1'b1;
							state_nx.phase     = PH_IDLE;
						end else begin
							state_nx.phase = PH_LEN;
						end
					end
					PH_LEN: begin
						// The length compare is done one bit wider so it never wraps.
						if ({1'b0, item.rx_byte} != {1'b0, state_q.want_len} + LEN_EXTRA) begin
							has_result         = 1'b1;
							result.kind        = KIND_FINAL;
							result.comm_status = ST_BADLEN;
							result.reply_id    = state_q.got_id;
							result.last        = 1'b1;
							state_nx.phase     = PH_IDLE;
						end else begin
							state_nx.running_sum = sum_plus_b;
							state_nx.phase       = PH_STAT;
						end
					end
					PH_STAT: begin
						state_nx.got_status  = item.rx_byte;
						state_nx.running_sum = sum_plus_b;
						state_nx.phase = (state_q.want_len == 8'd0) ? PH_CSUM : PH_DATA;
					end
					PH_DATA: begin
						state_nx.running_sum = sum_plus_b;
						has_result           = 1'b1;
						result.kind          = KIND_DATA;
						result.data_byte     = item.rx_byte;
						result.byte_index    = state_q.data_count;
						result.reply_id      = state_q.got_id;
						state_nx.data_count  = count_inc;
						if (count_inc >= state_q.want_len) begin
							state_nx.phase = PH_CSUM;
						end
					end
					PH_CSUM: begin
						has_result      = 1'b1;
						result.kind     = KIND_FINAL;
						result.reply_id = state_q.got_id;
						result.last     = 1'b1;
						state_nx.phase  = PH_IDLE;
						if (~state_q.running_sum != item.rx_byte) begin
							result.comm_status = ST_CRC;
						end else begin
							result.comm_status = ST_OK;
							result.servo_error = state_q.got_status;
						end
					end
					default: begin
						state_nx.phase = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ssrd_out_reg.sv @@
// Result register that holds one result until the receiver takes it.
`default_nettype none
module ssrd_out_reg
	import ssrd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire logic      load_valid,
	input  wire out_item_t load_data,
	output logic           room,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	logic      valid_q;
	out_item_t data_q;

	// The register can take a new result when empty or when its result leaves now.
	assign room      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/servo_status_reply_deframer_unit.sv @@
// Top level of the servo status reply deframer.
// Input channel (in_valid, in_stall, in_data) carries one item per transfer: a begin
// with the expected id and data length, a received bus byte, or a receive timeout.
// Output channel (out_valid, out_stall, out_data) carries data bytes of the reply and
// one final status per transaction, marked by last.
// An accepted item is captured in an input register; once the result register has
// room, the deframer logic updates its state and loads the result register. One
// item is taken per cycle as long as the output is not stalled; the input register
// and the result register each hold one item, so the input still takes one item
// while a result waits.
// While the receiver stalls, the result holds and in_stall rises once the input
// register is also full.
// Configuration: cfg_wr_en with cfg_index 0 writes hunt_limit, index 1 writes
// reply_enable; write only while no transaction is in flight.
// Reset clears all state to idle, hunt_limit to 10 and reply_enable to 1.
`default_nettype none
module servo_status_reply_deframer_unit
	import ssrd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_wr_en,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      advance;
	logic      has_result;
	out_item_t result;
	cfg_t      cfg_q;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hunt_limit   <= HUNT_DEFAULT;
			cfg_q.reply_enable <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HUNT_LIMIT:   cfg_q.hunt_limit   <= cfg_wdata;
				REG_REPLY_ENABLE: cfg_q.reply_enable <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	ssrd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.result     (result)
	);

	ssrd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_valid (has_result),
		.load_data  (result),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	// A new result can only come from an item that just left the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a pending item");

	// Data results never carry a status or the last mark.
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_DATA |->
			!out_data.last && out_data.comm_status == ST_OK && out_data.servo_error == 8'd0)
		else $error("data result carries final-status fields");

	// The last mark and the final kind always go together.
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last == out_data.kind)
		else $error("last mark disagrees with result kind");

	// The input side only stalls while the input register is full and a result is stalled at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire
